// File: hw/rtl/pta_pkg.sv
// shared types, constants and the cordic angle table for the turret aiming unit
package pta_pkg;

  localparam int DW      = 62;  // cordic x/y datapath width
  localparam int ZW      = 26;  // cordic angle accumulator width, 2^-16 degree
  localparam int INT_FRAC = 16;
  localparam int TAB_IW  = 5;   // index width of the atan table
  localparam int GAIN_Q16 = 107922;
  localparam int GAIN_W  = 18;  // signed width holding the gain constant
  localparam int SCALE_EXP = 56;

  typedef struct packed {
    logic              capture;    // latch a target item
    logic              pose;       // store own position
    logic              diff;       // form scaled offsets
    logic              load;       // load cordic with pre-rotation
    logic              sel_pitch;  // cordic source: pitch pass
    logic              iter;       // one cordic micro-rotation
    logic [TAB_IW-1:0] idx;        // micro-rotation index
    logic              wrap;       // form pitch command and raw yaw error
    logic              norm;       // one wrap step of the yaw error
    logic              split;      // split yaw error, issue result
  } cmd_t;

  typedef struct packed {
    logic norm_done;
  } status_t;

  // atan(2^-i) in degrees times 2^16, rounded
  function automatic logic [21:0] atan_tab(input logic [TAB_IW-1:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/pan_tilt_turret_aiming_top.sv
// a target transfer runs diff, yaw load, yaw micro-rotations, pitch load, pitch micro-rotations,
// wrap, norm with its wrap steps, and split; input stays blocked until the split step completes
// the shared cordic unit runs the yaw pass then the pitch pass, one micro-rotation a cycle
// a pose item leaves the unit ready and gives no result; split waits while the output is stalled
// reset: own position and mount height clear, both yaw commands return to 90 degrees
module pan_tilt_turret_aiming_top #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int COORD_WIDTH       = 24,
  parameter int ANGLE_FRAC_BITS   = 8
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write channel: mount height
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [15:0] cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        bottom_angle,
  output logic [15:0]        middle_angle,
  output logic [15:0]        top_angle
);

  pta_pkg::cmd_t    cmd;
  pta_pkg::status_t status;

  // the register write never stalls, so the channel is always open
  assign cfg_ready = 1'b1;

  // sequencer: owns the input and output handshakes and the cordic step count
  pta_ctrl #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and state; result fields are held in registers until the transfer
  pta_datapath #(
    .COORD_WIDTH     (COORD_WIDTH),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .bottom_angle (bottom_angle),
    .middle_angle (middle_angle),
    .top_angle    (top_angle)
  );

endmodule

// File: hw/rtl/pta_ctrl.sv
// sequencer for the turret aiming unit: handshakes and datapath commands
module pta_ctrl #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  output logic              out_valid,
  input  logic              out_ready,
  input  pta_pkg::status_t  status,
  output pta_pkg::cmd_t     cmd
);

  localparam int IW = $clog2(CORDIC_ITERATIONS);

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_DIFF       = 9'b000000010,
    S_YAW_LOAD   = 9'b000000100,
    S_YAW_ITER   = 9'b000001000,
    S_PITCH_LOAD = 9'b000010000,
    S_PITCH_ITER = 9'b000100000,
    S_WRAP       = 9'b001000000,
    S_NORM       = 9'b010000000,
    S_SPLIT      = 9'b100000000
  } state_t;

  state_t        state, state_next;
  logic [IW-1:0] cnt, cnt_next;
  logic          out_valid_next;
  logic          last_iter;
  logic          out_free;

  assign last_iter = (cnt == IW'(CORDIC_ITERATIONS - 1));
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.idx        = pta_pkg::TAB_IW'(cnt);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (operation) begin
            cmd.capture = 1'b1;
            state_next  = S_DIFF;
          end else begin
            cmd.pose = 1'b1;
          end
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_YAW_LOAD;
      end
      S_YAW_LOAD: begin
        cmd.load   = 1'b1;
        cnt_next   = '0;
        state_next = S_YAW_ITER;
      end
      S_YAW_ITER: begin
        cmd.iter = 1'b1;
        if (last_iter) begin
          state_next = S_PITCH_LOAD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_PITCH_LOAD: begin
        cmd.load      = 1'b1;
        cmd.sel_pitch = 1'b1;
        cnt_next      = '0;
        state_next    = S_PITCH_ITER;
      end
      S_PITCH_ITER: begin
        cmd.iter = 1'b1;
        if (last_iter) begin
          state_next = S_WRAP;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_WRAP: begin
        cmd.wrap   = 1'b1;
        state_next = S_NORM;
      end
      S_NORM: begin
        if (status.norm_done) begin
          state_next = S_SPLIT;
        end else begin
          cmd.norm = 1'b1;
        end
      end
      S_SPLIT: begin
        if (out_free) begin
          cmd.split      = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  // a target transfer starts a computation that blocks further input
  a_busy_after_target: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation |=> !in_ready)
    else $error("input taken right after a target transfer");

  // a pose transfer leaves the unit ready and produces no result
  a_pose_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !operation && !out_valid |=> in_ready && !out_valid)
    else $error("pose update produced a result");

  // a result appears only from the split step
  a_result_from_split: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_SPLIT))
    else $error("result raised outside split step");

  // the cordic counter never passes its last micro-rotation
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cmd.iter |-> cnt <= IW'(CORDIC_ITERATIONS - 1))
    else $error("cordic counter out of range");
`endif

endmodule

// File: hw/rtl/pta_datapath.sv
// datapath of the turret aiming unit: offsets, shared cordic, yaw split, state
module pta_datapath #(
  parameter int COORD_WIDTH     = 24,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  pta_pkg::cmd_t      cmd,
  output pta_pkg::status_t   status,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic               cfg_we,
  input  logic signed [15:0] cfg_data,
  output logic [15:0]        bottom_angle,
  output logic [15:0]        middle_angle,
  output logic [15:0]        top_angle
);

  localparam int DW    = pta_pkg::DW;
  localparam int ZW    = pta_pkg::ZW;
  localparam int CW    = COORD_WIDTH;
  localparam int SH    = pta_pkg::SCALE_EXP - CW;
  localparam int PSH   = pta_pkg::SCALE_EXP - CW - pta_pkg::INT_FRAC;
  localparam int PW    = CW + 2 + pta_pkg::GAIN_W;
  localparam int RSH   = pta_pkg::INT_FRAC - ANGLE_FRAC_BITS;
  localparam int AW    = ANGLE_FRAC_BITS + 14;
  localparam logic signed [AW-1:0] DEG90  = AW'(90 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [AW-1:0] DEG180 = AW'(180 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [AW-1:0] DEG360 = AW'(360 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [ZW-1:0] Z90    = ZW'(90 * (1 << pta_pkg::INT_FRAC));
  localparam logic signed [ZW-1:0] ZHALF  = ZW'(1 << (RSH - 1));
  localparam logic signed [pta_pkg::GAIN_W-1:0] GAIN = pta_pkg::GAIN_W'(pta_pkg::GAIN_Q16);

  logic signed [CW-1:0] own_x, own_y, own_z;
  logic signed [CW-1:0] tgt_x, tgt_y, tgt_z;
  logic signed [CW-1:0] in_x, in_y, in_z;
  logic signed [15:0]   mount_height;
  logic signed [DW-1:0] dxs, dys;
  logic signed [CW+1:0] dz;
  logic signed [PW-1:0] dzp;
  logic signed [DW-1:0] dzs;
  logic signed [DW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic                 czero;
  logic signed [DW-1:0] lx, ly;
  logic signed [DW-1:0] xs, ys;
  logic signed [ZW-1:0] tab;
  logic signed [AW-1:0] conv;
  logic signed [AW-1:0] yaw_aim;
  logic signed [AW-1:0] delta;
  logic [15:0]          top_pend;
  logic [15:0]          bottom_command, middle_command;
  logic signed [AW-1:0] bc, mc, dc, bsum, bot, mid;

  function automatic logic [15:0] clamp180(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] c;
    if (v < 0) begin
      c = '0;
    end else if (v > DEG180) begin
      c = DEG180;
    end else begin
      c = v;
    end
    return c[15:0];
  endfunction

  // low coordinate bits taken as two's complement
  assign in_x = CW'($unsigned(pos_x));
  assign in_y = CW'($unsigned(pos_y));
  assign in_z = CW'($unsigned(pos_z));

  assign dzs = DW'(dzp) <<< PSH;
  assign lx  = cmd.sel_pitch ? cx  : dxs;
  assign ly  = cmd.sel_pitch ? dzs : dys;
  assign xs  = cx >>> cmd.idx;
  assign ys  = cy >>> cmd.idx;
  assign tab = ZW'(pta_pkg::atan_tab(cmd.idx));

  // cordic angle rounded to the output step
  always_comb begin
    logic signed [ZW-1:0] zf;
    zf   = czero ? '0 : cz;
    conv = AW'((zf + ZHALF) >>> RSH);
  end

  assign bc = AW'(bottom_command);
  assign mc = AW'(middle_command);
  assign dc = delta - DEG180;
  assign bsum = bc + dc;

  // yaw error split between bottom and middle servo
  always_comb begin
    bot = bsum;
    mid = mc;
    if (dc > 0) begin
      if (bsum > DEG180) begin
        bot = DEG180;
        mid = mc + (dc - (DEG180 - bc));
      end
    end else begin
      if (bsum < 0) begin
        bot = '0;
        mid = mc + bsum;
      end
    end
  end

  assign status.norm_done = (delta >= 0) && (delta < DEG360);

  always_ff @(posedge clk) begin
    if (rst) begin
      own_x          <= '0;
      own_y          <= '0;
      own_z          <= '0;
      mount_height   <= '0;
      bottom_command <= DEG90[15:0];
      middle_command <= DEG90[15:0];
    end else begin
      if (cfg_we) begin
        mount_height <= cfg_data;
      end
      if (cmd.pose) begin
        own_x <= in_x;
        own_y <= in_y;
        own_z <= in_z;
      end
      if (cmd.split) begin
        bottom_command <= clamp180(bot);
        middle_command <= clamp180(mid);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tgt_x <= in_x;
      tgt_y <= in_y;
      tgt_z <= in_z;
    end
    if (cmd.diff) begin
      dxs <= DW'((CW + 1)'(tgt_x) - (CW + 1)'(own_x)) <<< SH;
      dys <= DW'((CW + 1)'(tgt_y) - (CW + 1)'(own_y)) <<< SH;
      dz  <= (CW + 2)'(tgt_z) - (CW + 2)'(own_z) - (CW + 2)'(mount_height);
    end
    if (cmd.load && !cmd.sel_pitch) begin
      dzp <= PW'(dz) * PW'(GAIN);
    end
    if (cmd.load) begin
      czero <= (lx == 0) && (ly == 0);
      if (lx < 0) begin
        if (ly >= 0) begin
          cx <= ly;
          cy <= -lx;
          cz <= Z90;
        end else begin
          cx <= -ly;
          cy <= lx;
          cz <= -Z90;
        end
      end else begin
        cx <= lx;
        cy <= ly;
        cz <= '0;
      end
    end else if (cmd.iter) begin
      if (cy > 0) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + tab;
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - tab;
      end
    end
    if (cmd.load && cmd.sel_pitch) begin
      yaw_aim <= conv;
    end
    if (cmd.wrap) begin
      top_pend <= clamp180(conv + DEG90);
      delta    <= DEG180 - bc - mc - yaw_aim + DEG180;
    end else if (cmd.norm) begin
      if (delta < 0) begin
        delta <= delta + DEG360;
      end else begin
        delta <= delta - DEG360;
      end
    end
    if (cmd.split) begin
      top_angle <= top_pend;
    end
  end

  assign bottom_angle = bottom_command;
  assign middle_angle = middle_command;

endmodule

// File: tb/tb_pan_tilt_turret_aiming_top.sv
// testbench for the turret aiming unit: random and directed aim items checked against a predictor
module tb_pan_tilt_turret_aiming_top;

  localparam int ITERS = 16;
  localparam int CW    = 24;
  localparam int AFB   = 8;
  localparam longint ONE_DEG = longint'(1) << AFB;
  localparam longint DEG90   = 90 * ONE_DEG;
  localparam longint DEG180  = 180 * ONE_DEG;
  localparam longint DEG360  = 360 * ONE_DEG;
  localparam logic OP_POSE   = 1'b0;
  localparam logic OP_TARGET = 1'b1;
  localparam int LATENCY     = 2 * ITERS + 12;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] bottom;
    logic [15:0] middle;
    logic [15:0] top;
  } aim_t;

  // floor shift for signed 64-bit values
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_deg(longint v);
    if (v < 0) return 0;
    if (v > DEG180) return DEG180;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint t [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                       14668, 7334, 3667, 1833, 917, 458, 229, 115,
                       57, 29, 14, 7, 4, 2, 1, 0};
    return t[i];
  endfunction

  // vectoring rotation: angle at 2^-16 degree, scaled magnitude out
  function automatic longint vector_angle(longint y, longint x, output longint mag);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 90 <<< 16;
      end else begin
        t = x; x = -y; y = t; z = -(90 <<< 16);
      end
    end
    for (int i = 0; i < ITERS && i < 24; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; z += atan_step(i);
      end else begin
        x = x - ys; y = y + xs; z -= atan_step(i);
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic longint round_angle(longint z);
    return floor_shr(z + (longint'(1) << (16 - AFB - 1)), 16 - AFB);
  endfunction

  // predictor state plus queue of pending aim commands
  class aim_scoreboard;
    longint own_x, own_y, own_z, bottom_cmd, middle_cmd, mount;
    aim_t pending[$];
    int errors, checked, targets, poses;

    function void clear();
      own_x = 0; own_y = 0; own_z = 0;
      bottom_cmd = DEG90; middle_cmd = DEG90; mount = 0;
      pending.delete();
    endfunction

    function void set_mount(logic signed [15:0] h);
      mount = h;
    endfunction

    function void note_item(logic op, logic signed [23:0] px, logic signed [23:0] py,
                            logic signed [23:0] pz);
      longint dx, dy, dz, mag, mag2, yaw, pitch, cur, err, bot, mid;
      aim_t a;
      if (op == OP_POSE) begin
        own_x = px; own_y = py; own_z = pz;
        poses++;
        return;
      end
      targets++;
      dx = longint'(px) - own_x;
      dy = longint'(py) - own_y;
      dz = longint'(pz) - own_z - mount;
      yaw = round_angle(vector_angle(dy <<< (56 - CW), dx <<< (56 - CW), mag));
      pitch = round_angle(vector_angle(dz * 107922 * (longint'(1) << (56 - CW - 16)),
                                       mag, mag2));
      cur = DEG180 - bottom_cmd - middle_cmd;
      err = cur - yaw + DEG180;
      err = ((err % DEG360) + DEG360) % DEG360 - DEG180;
      bot = bottom_cmd;
      mid = middle_cmd;
      if (err > 0) begin
        if (bottom_cmd + err > DEG180) begin
          mid = middle_cmd + err - (DEG180 - bottom_cmd);
          bot = DEG180;
        end else bot = bottom_cmd + err;
      end else begin
        if (bottom_cmd + err < 0) begin
          mid = middle_cmd + err + bottom_cmd;
          bot = 0;
        end else bot = bottom_cmd + err;
      end
      bot = clamp_deg(bot) & 16'hFFFF;
      mid = clamp_deg(mid) & 16'hFFFF;
      bottom_cmd = bot;
      middle_cmd = mid;
      a.bottom = bot[15:0];
      a.middle = mid[15:0];
      a.top = 16'(clamp_deg(pitch + DEG90));
      pending.push_back(a);
    endfunction

    function void check_result(aim_t got);
      aim_t exp_a;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h/%h/%h", $time, got.bottom, got.middle, got.top);
        errors++;
        return;
      end
      exp_a = pending.pop_front();
      checked++;
      if (got.bottom !== exp_a.bottom) begin
        $display("%0t bottom_angle expected %0d got %0d", $time, exp_a.bottom, got.bottom);
        errors++;
      end
      if (got.middle !== exp_a.middle) begin
        $display("%0t middle_angle expected %0d got %0d", $time, exp_a.middle, got.middle);
        errors++;
      end
      if (got.top !== exp_a.top) begin
        $display("%0t top_angle expected %0d got %0d", $time, exp_a.top, got.top);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic signed [15:0] cfg_data;
  logic in_valid, in_ready, operation;
  logic signed [23:0] pos_x, pos_y, pos_z;
  logic out_valid, out_ready;
  logic [15:0] bottom_angle, middle_angle, top_angle;

  aim_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  bit hold_off;
  longint cycles;

  pan_tilt_turret_aiming_top u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .bottom_angle(bottom_angle), .middle_angle(middle_angle), .top_angle(top_angle)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // watchdog on total cycles
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: ready decided at the falling edge, transfer checked at the rising edge
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{bottom_angle, middle_angle, top_angle});
  end

  // one input transfer, with optional idle before it; valid is left up after the transfer
  task automatic send_item(logic op, logic signed [23:0] x, logic signed [23:0] y,
                           logic signed [23:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    pos_x <= x; pos_y <= y; pos_z <= z;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, x, y, z);
    @(negedge clk);
  endtask

  // wait until every pending result is back, then wait out LATENCY as a margin
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_mount(logic signed [15:0] h);
    cfg_valid <= 1'b1;
    cfg_data <= h;
    do @(posedge clk); while (!cfg_ready);
    sb.set_mount(h);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);                   // full range
      1: return 24'($signed(24'($urandom_range(4000))) - 24'sd2000);
      2: return 24'($signed(24'($urandom_range(200000))) - 24'sd100000);
      default: return $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_item(OP_POSE, rand_coord(), rand_coord(), rand_coord());
      else send_item(OP_TARGET, rand_coord(), rand_coord(), rand_coord());
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    logic signed [15:0] heights [5] = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd1500, -16'sd700};
    sb = new();
    sb.clear();
    cycles = 0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1;
    cfg_valid = 0; cfg_data = 0;
    in_valid = 0; operation = OP_POSE;
    pos_x = 0; pos_y = 0; pos_z = 0;
    out_ready = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: axes, zero vector, straight up/down, extremes, wrap of the yaw split
    send_item(OP_TARGET, 0, 0, 0);
    send_item(OP_TARGET, 1000, 0, 0);
    send_item(OP_TARGET, 0, 1000, 0);
    send_item(OP_TARGET, -1000, 0, 0);
    send_item(OP_TARGET, 0, -1000, 0);
    send_item(OP_TARGET, -1000, -1, 0);
    send_item(OP_TARGET, 0, 0, 5000);
    send_item(OP_TARGET, 0, 0, -5000);
    send_item(OP_TARGET, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_item(OP_TARGET, -24'sh800000, -24'sh800000, -24'sh800000);
    send_item(OP_TARGET, 24'sh7FFFFF, -24'sh800000, 0);
    send_item(OP_POSE, -24'sh800000, 24'sh7FFFFF, -24'sh800000);
    send_item(OP_TARGET, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF);
    send_item(OP_POSE, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF);
    send_item(OP_TARGET, -24'sh800000, 24'sh7FFFFF, -24'sh800000);
    send_item(OP_POSE, 0, 0, 0);
    send_item(OP_TARGET, 10, 1, 3);
    send_item(OP_TARGET, 10, -1, -3);
    send_item(OP_TARGET, -10, 1, 0);
    send_item(OP_TARGET, -10, -1, 0);
    in_valid <= 1'b0;
    drain();

    // sweep mount height and the idling mix
    for (int p = 0; p < 5; p++) begin
      write_mount(heights[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      random_phase(170);
      drain();
    end

    // long receiver hold-off while the sender keeps offering items
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      random_phase(20);
    join
    drain();

    $display("covered %0d target and %0d pose transfers, %0d results checked",
             sb.targets, sb.poses, sb.checked);
    $display("mount heights at both extremes, four idling mixes, one long output stall");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: pan_tilt_turret_aiming_top.f
hw/rtl/pta_pkg.sv
hw/rtl/pta_ctrl.sv
hw/rtl/pta_datapath.sv
hw/rtl/pan_tilt_turret_aiming_top.sv
tb/tb_pan_tilt_turret_aiming_top.sv
